[rtl/core/lz78_phrase_encoder_unit_assert.svh]
// assertion macros shared by the encoder checks
`ifndef LZ78_PHRASE_ENCODER_UNIT_ASSERT_SVH
`define LZ78_PHRASE_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, idle in reset
`define LZ78PE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, idle in reset
`define LZ78PE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lz78pe_pkg.sv]
package lz78pe_pkg;

  // fixed field widths
  localparam int SymW    = 8;
  localparam int PhraseW = 10;
  localparam int LimitW  = 11;

  // phrase limit after reset
  localparam logic [LimitW-1:0] LimitRst = LimitW'(1024);

  // input word: one text byte
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            end_of_text;
  } sym_word_t;

  // output word: one codeword
  typedef struct packed {
    logic [PhraseW-1:0] phrase_index;
    logic [SymW-1:0]    mismatch_symbol;
    logic               has_symbol;
    logic               text_done;
  } code_word_t;

endpackage

[rtl/core/lz78pe_ram.sv]
module lz78pe_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, new data forwarded when both ports hit one entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rd_q <= wdata_i;
      end else begin
        rd_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_q;

endmodule

[rtl/core/lz78_phrase_encoder_unit.sv]
// LZ78 phrase encoder
// in channel: one text byte per word (symbol, end_of_text), in_valid_i / in_stall_o.
// out channel: one codeword per word (phrase_index, mismatch_symbol, has_symbol,
//   text_done), out_valid_o / out_stall_i; a byte that descends the trie and is
//   not the last of its text gives no codeword.
// cfg port: cfg_we_i writes phrase_limit from cfg_wdata_i; write only while idle.
// flow: one byte in the lookup at once; each reads the child table and then
//   the phrase key memory at the child found; the match decides the phrase that
//   addresses the next byte's table read, which is issued in that same cycle.
// output: a codeword's valid and word are registered at its byte's match step.
// reset: current phrase goes to the root, next free phrase to 1, limit to 1024.
//   no clearing pass is run: a child entry counts only if its index is below the
//   next free phrase and the key memory holds this very (phrase, byte) for it, so
//   the dictionary is empty at once after reset and after every text.
// stall: the output register holds its codeword while stalled; the next byte is
//   still taken and looked up, and it waits at the match step until the output
//   register frees up.
module lz78_phrase_encoder_unit
  import lz78pe_pkg::*;
#(
  parameter int unsigned DICT_SIZE = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sym_word_t         in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output code_word_t        out_word_o,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i
);

  // phrase index width and number of dictionary rows actually reachable
  localparam int unsigned DictW   = $clog2(DICT_SIZE);
  localparam int unsigned IdxW    = (DictW > LimitW) ? LimitW : DictW;
  localparam int unsigned Rows    = (DICT_SIZE < (2 ** LimitW)) ? DICT_SIZE : (2 ** LimitW);
  localparam int unsigned DictCap = (DICT_SIZE < (2 ** LimitW)) ? DICT_SIZE
                                                                : ((2 ** LimitW) - 1);
  localparam logic [LimitW-1:0] DictLim = LimitW'(DictCap);
  localparam int unsigned KeyW    = IdxW + SymW;

  logic [LimitW-1:0] limit_q;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [LimitW-1:0] next_q, next_d;
  logic [SymW-1:0]   sym_q;
  logic              last_q;
  logic              s1_q, s2_q;
  logic              out_valid_q;
  code_word_t        out_word_q;

  logic              accept, dec_go, hit, can_add, emit, add_en;
  logic [IdxW-1:0]   tbl_rd;
  logic [KeyW-1:0]   key_rd, slot;
  code_word_t        res;

  // handshake: one byte in the lookup at a time, match step waits on the output
  assign dec_go     = s2_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_q || (s2_q && !dec_go);
  assign accept     = in_valid_i && !in_stall_o;

  // child table: (phrase, byte) -> child phrase
  lz78pe_ram #(
    .DEPTH (Rows * (2 ** SymW)),
    .WIDTH (IdxW)
  ) u_child_ram (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i ({cur_d, in_word_i.symbol}),
    .we_i    (add_en),
    .waddr_i (slot),
    .wdata_i (IdxW'(next_q)),
    .rdata_o (tbl_rd)
  );

  // key memory: phrase -> the (parent, byte) it was created at
  lz78pe_ram #(
    .DEPTH (Rows),
    .WIDTH (KeyW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .re_i    (s1_q),
    .raddr_i (tbl_rd),
    .we_i    (add_en),
    .waddr_i (IdxW'(next_q)),
    .wdata_i (slot),
    .rdata_o (key_rd)
  );

  // match check for the byte at its match step
  assign slot    = {cur_q, sym_q};
  assign hit     = (tbl_rd != '0) && (LimitW'(tbl_rd) < next_q) && (key_rd == slot);
  assign can_add = (next_q < limit_q) && (next_q < DictLim);

  // descend or emit, add a phrase, restart at end of text
  always_comb begin
    cur_d  = cur_q;
    next_d = next_q;
    emit   = 1'b0;
    add_en = 1'b0;
    res    = '0;
    if (dec_go) begin
      if (hit) begin
        cur_d = tbl_rd;
        if (last_q) begin
          emit             = 1'b1;
          res.phrase_index = PhraseW'(tbl_rd);
          res.text_done    = 1'b1;
        end
      end else begin
        emit                = 1'b1;
        res.phrase_index    = PhraseW'(cur_q);
        res.mismatch_symbol = sym_q;
        res.has_symbol      = 1'b1;
        res.text_done       = last_q;
        cur_d               = '0;
        if (can_add) begin
          add_en = 1'b1;
          next_d = next_q + LimitW'(1);
        end
      end
      if (last_q) begin
        cur_d  = '0;
        next_d = LimitW'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitRst;
      cur_q       <= '0;
      next_q      <= LimitW'(1);
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      cur_q  <= cur_d;
      next_q <= next_d;
      s1_q   <= accept;
      s2_q   <= s1_q || (s2_q && !dec_go);
      if (dec_go && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q  <= in_word_i.symbol;
      last_q <= in_word_i.end_of_text;
    end
    if (dec_go && emit) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/core/lz78pe_checker.sv]
`include "lz78_phrase_encoder_unit_assert.svh"

module lz78pe_checker
  import lz78pe_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_i,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input code_word_t out_word_i
);

  // a held codeword keeps its valid and its contents
  `LZ78PE_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i, "codeword dropped while stalled")
  `LZ78PE_ASSERT_NEXT(a_out_stable, out_valid_i && out_stall_i, $stable(out_word_i), "stalled codeword changed")

  // no two bytes are taken back to back
  `LZ78PE_ASSERT_NEXT(a_in_spacing, in_valid_i && !in_stall_i, in_stall_i, "byte taken in back to back cycles")

  // a fresh codeword must trace back to a taken byte
  `LZ78PE_ASSERT_NOW(a_out_origin, $rose(out_valid_i), $past(in_valid_i && !in_stall_i, 3), "codeword without a byte")

  // a codeword with no trailing byte closes the text and carries a zero byte
  `LZ78PE_ASSERT_NOW(a_no_sym_final, out_valid_i && !out_word_i.has_symbol, out_word_i.text_done && (out_word_i.mismatch_symbol == '0), "bad final codeword")

endmodule

bind lz78_phrase_encoder_unit lz78pe_checker u_lz78pe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);
